/* rtl/core/psd_pkg.sv */
// Shared types and constants for the per-station sequence dedup core.
// Holds the table sizing, status codes, register indexes and table port structs.
// No dependencies.
package psd_pkg;

  localparam int STATION_COUNT = 32;
  localparam int ADDR_W = (STATION_COUNT > 1) ? $clog2(STATION_COUNT) : 1;
  localparam int SEQ_W = 8;

  localparam logic [SEQ_W-1:0] SEQ_LAST = 8'd254;
  localparam logic [SEQ_W-1:0] SEQ_NONE = 8'd255;
  localparam logic [SEQ_W-1:0] SHORT_LEN = 8'd5;

  localparam logic [SEQ_W-1:0] TX_SEQ_INIT = 8'd0;
  localparam logic [SEQ_W-1:0] RX_SEQ_INIT = SEQ_NONE;

  localparam logic [1:0] CFG_LINK_READY = 2'd0;
  localparam logic [1:0] CFG_TX_BCAST = 2'd1;
  localparam logic [1:0] CFG_RX_BCAST = 2'd2;

  typedef enum logic [3:0] {
    ST_TX_REFUSED = 4'd0,
    ST_TX_BCAST   = 4'd1,
    ST_TX_SEQ     = 4'd2,
    ST_TX_NOSEQ   = 4'd3,
    ST_RX_SHORT   = 4'd4,
    ST_RX_BCAST   = 4'd5,
    ST_RX_FWD     = 4'd6,
    ST_RX_DUP     = 4'd7,
    ST_RX_BADSRC  = 4'd8
  } status_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } tbl_rd_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [SEQ_W-1:0]  data;
  } tbl_wr_t;

endpackage

/* rtl/core/per_station_sequence_dedup_core.sv */
// Top level of the per-station sequence numbering and duplicate suppression core.
// Depends on psd_pkg and psd_tbl.
//
// Channel  Dir  tdata (low bit up)                         tuser
// in_      in   station_id, target_id, packet_length, seq  mode
// out_     out  seq_out, frame_length, zero fill           status
// cfg_     in   write enable, register index, write data   -
//
// One request per cycle is sustained while out_ is ready: the table read issues at
// acceptance and the table update happens as the request leaves stage 1, with the
// written entry forwarded to a read of the same station in that cycle.
// Reset is synchronous; per-entry valid bits clear at once, so there is no clearing
// pass. A stalled output holds stage 1, and a full stage 1 stops acceptance.
module per_station_sequence_dedup_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // station_id, target_id, packet_length, seq_in
  input  logic        in_tuser,   // mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // seq_out, frame_length, zero fill
  output logic [3:0]  out_tuser,  // status
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_wdata
);

  logic       link_ready_r;
  logic [7:0] tx_bcast_r;
  logic [7:0] rx_bcast_r;

  logic       s1_valid_r;
  logic       s1_mode_r;
  logic [7:0] s1_station_r;
  logic [7:0] s1_target_r;
  logic [7:0] s1_len_r;
  logic [7:0] s1_seq_r;

  logic             out_valid_r;
  psd_pkg::status_t out_status_r;
  logic [7:0]       out_seq_r;
  logic [8:0]       out_len_r;

  logic             s1_fire;
  logic             in_fire;
  logic             s1_in_range;
  psd_pkg::status_t st_c;
  logic [7:0]       seq_c;
  logic [8:0]       len_c;

  psd_pkg::tbl_rd_t tbl_rd;
  psd_pkg::tbl_wr_t tx_wr;
  psd_pkg::tbl_wr_t rx_wr;
  logic [7:0]       tx_q;
  logic [7:0]       rx_q;

  assign s1_fire   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_fire;
  assign in_fire   = in_tvalid && in_tready;

  assign tbl_rd.en   = in_fire;
  assign tbl_rd.addr = in_tdata[psd_pkg::ADDR_W-1:0];

  psd_tbl u_tx_tbl (
    .clk      (clk),
    .rst_n    (rst_n),
    .rst_value(psd_pkg::TX_SEQ_INIT),
    .rd       (tbl_rd),
    .wr       (tx_wr),
    .rd_data  (tx_q)
  );

  psd_tbl u_rx_tbl (
    .clk      (clk),
    .rst_n    (rst_n),
    .rst_value(psd_pkg::RX_SEQ_INIT),
    .rd       (tbl_rd),
    .wr       (rx_wr),
    .rd_data  (rx_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_ready_r <= 1'b0;
      tx_bcast_r   <= 8'hFF;
      rx_bcast_r   <= 8'hFF;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        psd_pkg::CFG_LINK_READY: link_ready_r <= cfg_wdata[0];
        psd_pkg::CFG_TX_BCAST:   tx_bcast_r   <= cfg_wdata;
        psd_pkg::CFG_RX_BCAST:   rx_bcast_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign s1_in_range = {1'b0, s1_station_r} < 9'(psd_pkg::STATION_COUNT);

  always_comb begin
    st_c       = psd_pkg::ST_TX_REFUSED;
    seq_c      = 8'd0;
    len_c      = 9'd0;
    tx_wr.en   = 1'b0;
    tx_wr.addr = s1_station_r[psd_pkg::ADDR_W-1:0];
    tx_wr.data = (tx_q >= psd_pkg::SEQ_LAST) ? 8'd0 : tx_q + 8'd1;
    rx_wr.en   = 1'b0;
    rx_wr.addr = s1_station_r[psd_pkg::ADDR_W-1:0];
    rx_wr.data = s1_seq_r;
    if (!s1_mode_r) begin
      if (!link_ready_r) begin
        st_c = psd_pkg::ST_TX_REFUSED;
      end else if (s1_station_r == tx_bcast_r) begin
        st_c  = psd_pkg::ST_TX_BCAST;
        len_c = {1'b0, s1_len_r};
      end else if (s1_in_range) begin
        st_c     = psd_pkg::ST_TX_SEQ;
        seq_c    = tx_q;
        len_c    = {1'b0, s1_len_r} + 9'd1;
        tx_wr.en = s1_fire;
      end else begin
        st_c  = psd_pkg::ST_TX_NOSEQ;
        seq_c = psd_pkg::SEQ_NONE;
        len_c = {1'b0, s1_len_r} + 9'd1;
      end
    end else begin
      if (s1_len_r <= psd_pkg::SHORT_LEN) begin
        st_c = psd_pkg::ST_RX_SHORT;
      end else if (s1_target_r == rx_bcast_r) begin
        st_c  = psd_pkg::ST_RX_BCAST;
        len_c = {1'b0, s1_len_r};
      end else if (!s1_in_range) begin
        st_c = psd_pkg::ST_RX_BADSRC;
      end else if (s1_seq_r == rx_q) begin
        st_c  = psd_pkg::ST_RX_DUP;
        seq_c = s1_seq_r;
      end else begin
        st_c     = psd_pkg::ST_RX_FWD;
        seq_c    = s1_seq_r;
        len_c    = {1'b0, s1_len_r} - 9'd1;
        rx_wr.en = s1_fire && (s1_seq_r != psd_pkg::SEQ_NONE);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_mode_r    <= in_tuser;
      s1_station_r <= in_tdata[7:0];
      s1_target_r  <= in_tdata[15:8];
      s1_len_r     <= in_tdata[23:16];
      s1_seq_r     <= in_tdata[31:24];
    end
    if (s1_fire) begin
      out_status_r <= st_c;
      out_seq_r    <= seq_c;
      out_len_r    <= len_c;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_len_r, out_seq_r};
  assign out_tuser  = out_status_r;

`ifndef NO_ASSERTIONS
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_valid_r && !out_tready |=> s1_valid_r)
    else $error("stage 1 request lost under output stall");

  a_wr_on_fire: assert property (@(posedge clk) disable iff (!rst_n)
    (tx_wr.en || rx_wr.en) |-> s1_fire)
    else $error("table write without a completing request");

  a_one_table: assert property (@(posedge clk) disable iff (!rst_n)
    !(tx_wr.en && rx_wr.en))
    else $error("both tables written in one cycle");

  a_rx_no_none: assert property (@(posedge clk) disable iff (!rst_n)
    rx_wr.en |-> (rx_wr.data != psd_pkg::SEQ_NONE))
    else $error("receive table written with the no-sequence value");

  a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> s1_valid_r)
    else $error("accepted request did not reach stage 1");
`endif

endmodule

/* rtl/core/psd_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module psd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/psd_tbl.sv */
// One per-station sequence table: RAM, per-entry valid bits and write forwarding.
// Unwritten entries read as rst_value. Depends on psd_pkg and psd_ram.
module psd_tbl (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [psd_pkg::SEQ_W-1:0] rst_value,
  input  psd_pkg::tbl_rd_t         rd,
  input  psd_pkg::tbl_wr_t         wr,
  output logic [psd_pkg::SEQ_W-1:0] rd_data
);

  logic [psd_pkg::STATION_COUNT-1:0] valid_r;
  logic                              vld_r;
  logic                              vld_nxt;
  logic                              fwd_hit_r;
  logic [psd_pkg::SEQ_W-1:0]         fwd_data_r;
  logic [psd_pkg::SEQ_W-1:0]         ram_q;

  psd_ram #(
    .WIDTH(psd_pkg::SEQ_W),
    .DEPTH(psd_pkg::STATION_COUNT)
  ) u_ram (
    .clk  (clk),
    .we   (wr.en),
    .waddr(wr.addr),
    .wdata(wr.data),
    .re   (rd.en),
    .raddr(rd.addr),
    .rdata(ram_q)
  );

  always_comb begin
    vld_nxt = 1'b0;
    if ({1'b0, rd.addr} < (psd_pkg::ADDR_W + 1)'(psd_pkg::STATION_COUNT)) begin
      vld_nxt = valid_r[rd.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= '0;
      vld_r     <= 1'b0;
      fwd_hit_r <= 1'b0;
    end else begin
      if (wr.en) begin
        valid_r[wr.addr] <= 1'b1;
      end
      if (rd.en) begin
        vld_r     <= vld_nxt;
        fwd_hit_r <= wr.en && (wr.addr == rd.addr);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      fwd_data_r <= wr.data;
    end
  end

  assign rd_data = fwd_hit_r ? fwd_data_r : (vld_r ? ram_q : rst_value);

endmodule

/* tb/tb_per_station_sequence_dedup_core.sv */
// Self-checking testbench for per_station_sequence_dedup_core: directed table, a sequence
// wrap phase and random requests under several register settings, checked by a predictor.
// Depends on psd_pkg and the core RTL.
module tb_per_station_sequence_dedup_core;

  localparam int STATIONS = 32;
  localparam logic [7:0] SEQ_WRAP_AT = 8'd254;
  localparam logic [7:0] NO_SEQ = 8'd255;
  localparam logic [7:0] RX_SHORT_MAX = 8'd5;
  localparam bit MODE_TX = 1'b0;
  localparam bit MODE_RX = 1'b1;
  localparam logic [1:0] CFG_UNUSED = 2'd3;
  localparam int IDLE_PAD = 6;
  localparam int HOLD_CYCLES = 80;
  localparam int WRAP_ITEMS = 258;
  localparam int PHASE_ITEMS = 110;
  localparam int NUM_PHASES = 6;
  localparam int NUM_ROWS = 30;
  localparam int MAX_PRINTS = 100;

  typedef enum logic [1:0] {ROW_CFG, ROW_REQ, ROW_CHK} row_kind_t;

  typedef struct packed {
    bit       mode;
    bit [7:0] station;
    bit [7:0] target;
    bit [7:0] len;
    bit [7:0] seq;
  } frame_req_t;

  typedef struct packed {
    psd_pkg::status_t status;
    bit [7:0]         seq;
    bit [8:0]         len;
  } frame_res_t;

  typedef struct packed {
    row_kind_t        kind;
    logic [1:0]       reg_idx;
    logic [7:0]       reg_val;
    bit               mode;
    bit [7:0]         station;
    bit [7:0]         target;
    bit [7:0]         len;
    bit [7:0]         seq;
    psd_pkg::status_t status;
    bit [7:0]         seq_out;
    bit [8:0]         frame_len;
  } dir_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // station_id, target_id, packet_length, seq_in
  logic        in_tuser;   // mode
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;  // seq_out, frame_length, zero fill
  logic [3:0]  out_tuser;  // status
  logic        cfg_wr_en;
  logic [1:0]  cfg_index;
  logic [7:0]  cfg_wdata;

  bit          row_typed;
  frame_res_t  row_typed_res;

  bit          cfg_link_ready;
  logic [7:0]  cfg_tx_bcast;
  logic [7:0]  cfg_rx_bcast;
  logic [7:0]  next_seq_by_station [STATIONS];
  logic [7:0]  last_rx_by_station [STATIONS];

  frame_res_t  pending_results [$];
  dir_row_t    dir_rows [NUM_ROWS];

  int          mismatch_count = 0;
  int          requests_sent = 0;
  int          results_checked = 0;
  int          reg_writes = 0;
  bit          gaps_on = 1'b1;
  bit          stalls_on = 1'b1;
  bit          hold_request = 1'b0;
  bit          cfg_open = 1'b0;

  per_station_sequence_dedup_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("Timeout: the run did not drain in time.");
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic frame_res_t predict_frame(frame_req_t r);
    frame_res_t o;
    logic [7:0] cur;
    o.status = psd_pkg::ST_TX_REFUSED;
    o.seq = 8'd0;
    o.len = 9'd0;
    if (r.mode == MODE_TX) begin
      if (!cfg_link_ready) begin
        o.status = psd_pkg::ST_TX_REFUSED;
      end else if (r.station == cfg_tx_bcast) begin
        o.status = psd_pkg::ST_TX_BCAST;
        o.len = {1'b0, r.len};
      end else if (r.station < STATIONS) begin
        cur = next_seq_by_station[r.station[4:0]];
        o.status = psd_pkg::ST_TX_SEQ;
        o.seq = cur;
        o.len = {1'b0, r.len} + 9'd1;
        next_seq_by_station[r.station[4:0]] = (cur >= SEQ_WRAP_AT) ? 8'd0 : cur + 8'd1;
      end else begin
        o.status = psd_pkg::ST_TX_NOSEQ;
        o.seq = NO_SEQ;
        o.len = {1'b0, r.len} + 9'd1;
      end
    end else if (r.len <= RX_SHORT_MAX) begin
      o.status = psd_pkg::ST_RX_SHORT;
    end else if (r.target == cfg_rx_bcast) begin
      o.status = psd_pkg::ST_RX_BCAST;
      o.len = {1'b0, r.len};
    end else if (r.station >= STATIONS) begin
      o.status = psd_pkg::ST_RX_BADSRC;
    end else if (r.seq == last_rx_by_station[r.station[4:0]]) begin
      o.status = psd_pkg::ST_RX_DUP;
      o.seq = r.seq;
    end else begin
      if (r.seq != NO_SEQ) last_rx_by_station[r.station[4:0]] = r.seq;
      o.status = psd_pkg::ST_RX_FWD;
      o.seq = r.seq;
      o.len = {1'b0, r.len} - 9'd1;
    end
    return o;
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTS)
      $display("Mismatch on result %0d: %s is %0d, expected %0d",
               results_checked, field, got, want);
  endtask

  always @(posedge clk) begin : monitor
    frame_req_t acc;
    frame_res_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        acc.mode = in_tuser;
        acc.station = in_tdata[7:0];
        acc.target = in_tdata[15:8];
        acc.len = in_tdata[23:16];
        acc.seq = in_tdata[31:24];
        want = predict_frame(acc);
        if (row_typed) want = row_typed_res;
        pending_results.push_back(want);
      end
      if (out_tvalid && out_tready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result, status", int'(out_tuser), -1);
        end else begin
          want = pending_results.pop_front();
          if (out_tuser !== want.status)
            report_mismatch("status", int'(out_tuser), int'(want.status));
          if (out_tdata[7:0] !== want.seq)
            report_mismatch("seq_out", int'(out_tdata[7:0]), int'(want.seq));
          if (out_tdata[16:8] !== want.len)
            report_mismatch("frame_length", int'(out_tdata[16:8]), int'(want.len));
          if (out_tdata[23:17] !== 7'd0)
            report_mismatch("zero fill", int'(out_tdata[23:17]), 0);
        end
        results_checked++;
      end
    end
  end

  initial begin : receiver
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left = 0;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst_n) begin
        out_tready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        out_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (stalls_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 6) - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic close_cfg();
    if (cfg_open) begin
      cfg_wr_en <= 1'b0;
      cfg_open = 1'b0;
    end
  endtask

  task automatic send_req(frame_req_t r, bit typed, frame_res_t res);
    close_cfg();
    in_tvalid <= 1'b1;
    in_tuser <= r.mode;
    in_tdata <= {r.seq, r.len, r.target, r.station};
    row_typed <= typed;
    row_typed_res <= res;
    do @(posedge clk); while (!in_tready);
    requests_sent++;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    close_cfg();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (IDLE_PAD) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_open = 1'b1;
    reg_writes++;
    case (idx)
      psd_pkg::CFG_LINK_READY: cfg_link_ready = val[0];
      psd_pkg::CFG_TX_BCAST:   cfg_tx_bcast = val;
      psd_pkg::CFG_RX_BCAST:   cfg_rx_bcast = val;
      default: ;
    endcase
  endtask

  task automatic set_config(bit link, logic [7:0] txb, logic [7:0] rxb);
    wait_idle();
    write_reg(psd_pkg::CFG_LINK_READY, {7'd0, link});
    write_reg(psd_pkg::CFG_TX_BCAST, txb);
    write_reg(psd_pkg::CFG_RX_BCAST, rxb);
  endtask

  function automatic frame_req_t random_req();
    frame_req_t r;
    int pick;
    r.mode = 1'($urandom_range(0, 1));
    pick = $urandom_range(0, 99);
    if (pick < 70) r.station = 8'($urandom_range(0, STATIONS - 1));
    else if (pick < 80) r.station = cfg_tx_bcast;
    else if (pick < 90) r.station = 8'($urandom_range(STATIONS, 255));
    else r.station = 8'($urandom_range(0, 255));
    r.target = ($urandom_range(0, 99) < 15) ? cfg_rx_bcast : 8'($urandom_range(0, 255));
    pick = $urandom_range(0, 99);
    if (pick < 15) r.len = 8'($urandom_range(0, 6));
    else if (pick < 25) r.len = 8'($urandom_range(250, 255));
    else r.len = 8'($urandom_range(0, 255));
    pick = $urandom_range(0, 99);
    if (pick < 30 && r.station < STATIONS) r.seq = last_rx_by_station[r.station[4:0]];
    else if (pick < 40) r.seq = NO_SEQ;
    else if (pick < 50) r.seq = SEQ_WRAP_AT;
    else r.seq = 8'($urandom_range(0, 255));
    return r;
  endfunction

  initial begin : stimulus
    frame_req_t r;
    frame_res_t res;
    dir_row_t row;
    in_tvalid = 1'b0;
    in_tdata = 32'd0;
    in_tuser = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = psd_pkg::CFG_LINK_READY;
    cfg_wdata = 8'd0;
    row_typed = 1'b0;
    row_typed_res = '0;
    rst_n = 1'b0;
    cfg_link_ready = 1'b0;
    cfg_tx_bcast = 8'd255;
    cfg_rx_bcast = 8'd255;
    for (int i = 0; i < STATIONS; i++) begin
      next_seq_by_station[i] = 8'd0;
      last_rx_by_station[i] = NO_SEQ;
    end

    dir_rows = '{
      '{ROW_CHK, psd_pkg::CFG_LINK_READY, 8'd0, MODE_TX, 8'd0, 8'd0, 8'd10, 8'd0,
        psd_pkg::ST_TX_REFUSED, 8'd0, 9'd0},
      '{ROW_CHK, psd_pkg::CFG_LINK_READY, 8'd0, MODE_TX, 8'd255, 8'd0, 8'd10, 8'd0,
        psd_pkg::ST_TX_REFUSED, 8'd0, 9'd0},
      '{ROW_CHK, psd_pkg::CFG_LINK_READY, 8'd0, MODE_RX, 8'd0, 8'd0, 8'd5, 8'd9,
        psd_pkg::ST_RX_SHORT, 8'd0, 9'd0},
      '{ROW_CHK, psd_pkg::CFG_LINK_READY, 8'd0, MODE_RX, 8'd0, 8'd0, 8'd0, 8'd0,
        psd_pkg::ST_RX_SHORT, 8'd0, 9'd0},
      '{ROW_CHK, psd_pkg::CFG_LINK_READY, 8'd0, MODE_RX, 8'd3, 8'd255, 8'd6, 8'd1,
        psd_pkg::ST_RX_BCAST, 8'd0, 9'd6},
      '{ROW_CHK, psd_pkg::CFG_LINK_READY, 8'd0, MODE_RX, 8'd32, 8'd0, 8'd100, 8'd1,
        psd_pkg::ST_RX_BADSRC, 8'd0, 9'd0},
      '{ROW_CHK, psd_pkg::CFG_LINK_READY, 8'd0, MODE_RX, 8'd255, 8'd254, 8'd255, 8'd0,
        psd_pkg::ST_RX_BADSRC, 8'd0, 9'd0},
      '{ROW_CHK, psd_pkg::CFG_LINK_READY, 8'd0, MODE_RX, 8'd1, 8'd0, 8'd6, 8'd255,
        psd_pkg::ST_RX_DUP, 8'd255, 9'd0},
      '{ROW_CHK, psd_pkg::CFG_LINK_READY, 8'd0, MODE_RX, 8'd0, 8'd0, 8'd255, 8'd0,
        psd_pkg::ST_RX_FWD, 8'd0, 9'd254},
      '{ROW_CHK, psd_pkg::CFG_LINK_READY, 8'd0, MODE_RX, 8'd0, 8'd0, 8'd20, 8'd0,
        psd_pkg::ST_RX_DUP, 8'd0, 9'd0},
      '{ROW_CHK, psd_pkg::CFG_LINK_READY, 8'd0, MODE_RX, 8'd31, 8'd1, 8'd6, 8'd254,
        psd_pkg::ST_RX_FWD, 8'd254, 9'd5},
      '{ROW_REQ, psd_pkg::CFG_LINK_READY, 8'd0, MODE_RX, 8'd31, 8'd1, 8'd30, 8'd255,
        psd_pkg::ST_TX_REFUSED, 8'd0, 9'd0},
      '{ROW_REQ, psd_pkg::CFG_LINK_READY, 8'd0, MODE_RX, 8'd31, 8'd1, 8'd30, 8'd254,
        psd_pkg::ST_TX_REFUSED, 8'd0, 9'd0},
      '{ROW_CFG, psd_pkg::CFG_LINK_READY, 8'd1, MODE_TX, 8'd0, 8'd0, 8'd0, 8'd0,
        psd_pkg::ST_TX_REFUSED, 8'd0, 9'd0},
      '{ROW_CHK, psd_pkg::CFG_LINK_READY, 8'd0, MODE_TX, 8'd255, 8'd0, 8'd0, 8'd0,
        psd_pkg::ST_TX_BCAST, 8'd0, 9'd0},
      '{ROW_CHK, psd_pkg::CFG_LINK_READY, 8'd0, MODE_TX, 8'd0, 8'd0, 8'd0, 8'd0,
        psd_pkg::ST_TX_SEQ, 8'd0, 9'd1},
      '{ROW_CHK, psd_pkg::CFG_LINK_READY, 8'd0, MODE_TX, 8'd0, 8'd0, 8'd255, 8'd0,
        psd_pkg::ST_TX_SEQ, 8'd1, 9'd256},
      '{ROW_CHK, psd_pkg::CFG_LINK_READY, 8'd0, MODE_TX, 8'd31, 8'd0, 8'd7, 8'd0,
        psd_pkg::ST_TX_SEQ, 8'd0, 9'd8},
      '{ROW_CHK, psd_pkg::CFG_LINK_READY, 8'd0, MODE_TX, 8'd32, 8'd0, 8'd255, 8'd0,
        psd_pkg::ST_TX_NOSEQ, 8'd255, 9'd256},
      '{ROW_CHK, psd_pkg::CFG_LINK_READY, 8'd0, MODE_TX, 8'd254, 8'd77, 8'd3, 8'd0,
        psd_pkg::ST_TX_NOSEQ, 8'd255, 9'd4},
      '{ROW_CFG, psd_pkg::CFG_TX_BCAST, 8'd0, MODE_TX, 8'd0, 8'd0, 8'd0, 8'd0,
        psd_pkg::ST_TX_REFUSED, 8'd0, 9'd0},
      '{ROW_CFG, psd_pkg::CFG_RX_BCAST, 8'd0, MODE_TX, 8'd0, 8'd0, 8'd0, 8'd0,
        psd_pkg::ST_TX_REFUSED, 8'd0, 9'd0},
      '{ROW_CFG, CFG_UNUSED, 8'hA5, MODE_TX, 8'd0, 8'd0, 8'd0, 8'd0,
        psd_pkg::ST_TX_REFUSED, 8'd0, 9'd0},
      '{ROW_CHK, psd_pkg::CFG_LINK_READY, 8'd0, MODE_TX, 8'd0, 8'd0, 8'd9, 8'd0,
        psd_pkg::ST_TX_BCAST, 8'd0, 9'd9},
      '{ROW_CHK, psd_pkg::CFG_LINK_READY, 8'd0, MODE_RX, 8'd0, 8'd0, 8'd6, 8'd3,
        psd_pkg::ST_RX_BCAST, 8'd0, 9'd6},
      '{ROW_REQ, psd_pkg::CFG_LINK_READY, 8'd0, MODE_TX, 8'd1, 8'd0, 8'd40, 8'd0,
        psd_pkg::ST_TX_REFUSED, 8'd0, 9'd0},
      '{ROW_REQ, psd_pkg::CFG_LINK_READY, 8'd0, MODE_RX, 8'd255, 8'd255, 8'd5, 8'd0,
        psd_pkg::ST_TX_REFUSED, 8'd0, 9'd0},
      '{ROW_CFG, psd_pkg::CFG_LINK_READY, 8'd0, MODE_TX, 8'd0, 8'd0, 8'd0, 8'd0,
        psd_pkg::ST_TX_REFUSED, 8'd0, 9'd0},
      '{ROW_REQ, psd_pkg::CFG_LINK_READY, 8'd0, MODE_RX, 8'd2, 8'd3, 8'd50, 8'd17,
        psd_pkg::ST_TX_REFUSED, 8'd0, 9'd0},
      '{ROW_REQ, psd_pkg::CFG_LINK_READY, 8'd0, MODE_TX, 8'd2, 8'd0, 8'd1, 8'd0,
        psd_pkg::ST_TX_REFUSED, 8'd0, 9'd0}
    };

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.kind == ROW_CFG) begin
        if (!cfg_open) wait_idle();
        write_reg(row.reg_idx, row.reg_val);
      end else begin
        r = {row.mode, row.station, row.target, row.len, row.seq};
        res = {row.status, row.seq_out, row.frame_len};
        send_req(r, row.kind == ROW_CHK, res);
      end
    end

    // Enough requests to one station to run its transmit number through the wrap.
    set_config(1'b1, 8'd255, 8'd255);
    res = '0;
    for (int n = 0; n < WRAP_ITEMS; n++) begin
      r = {MODE_TX, 8'd7, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
           8'($urandom_range(0, 255))};
      send_req(r, 1'b0, res);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: set_config(1'b1, 8'd255, 8'd255);
        1: set_config(1'b1, 8'd0, 8'd0);
        2: set_config(1'b0, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        3: set_config(1'b1, 8'd31, 8'd128);
        4: set_config(1'b1, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        default: set_config(1'b1, 8'd200, 8'd1);
      endcase
      gaps_on = (p < 3);
      stalls_on = (p < 4);
      if (p == 3) hold_request = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        r = random_req();
        send_req(r, 1'b0, res);
      end
    end

    wait_idle();
    $display("Run covered %0d requests over %0d register writes, sequence wrap and a long",
             requests_sent, reg_writes);
    $display("output stall; %0d results compared, %0d mismatches.",
             results_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/psd_pkg.sv
rtl/core/psd_ram.sv
rtl/core/psd_tbl.sv
rtl/core/per_station_sequence_dedup_core.sv
tb/tb_per_station_sequence_dedup_core.sv
